// ----- rtl/lkv_pkg.sv -----
// Shared request codes, widths and controller/datapath interface types for the LRU cache.
package lkv_pkg;

  // Request codes
  localparam logic [1:0] REQ_GET = 2'd0;
  localparam logic [1:0] REQ_PUT = 2'd1;
  localparam logic [1:0] REQ_DEL = 2'd2;
  localparam logic [1:0] REQ_NOP = 2'd3;

  // Payload and capacity register widths
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned CAP_BITS  = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the input beat
    logic lookup;    // register the key match and replacement target
    logic touch;     // move the target slot to most recent
    logic drop;      // invalidate the target slot
    logic insert;    // place the key in the lowest free slot
    logic mem_wr;    // overwrite the payload of the target slot
    logic load_out;  // load the result register
  } lkv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       hit;
    logic       full;
  } lkv_sts_t;

endpackage

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the fully associative key-value cache with LRU replacement.
//
// Fully associative key-value cache with least-recently-used replacement. Each input beat
// is a get, put or remove on one key (only the low KEY_BITS bits of in_req_key take part);
// each produces exactly one result beat, in order. All ENTRIES keys are compared in parallel
// and every slot keeps a recency rank, so the least recent slot is the one whose rank equals
// occupancy minus one. A request is sequenced as capture, lookup, update and result load; a
// put of a new key takes a second update state (ST_INS), since the eviction and the insertion
// into the lowest free slot are separate updates. The result register frees the input side,
// so a new beat is taken while the previous result is still stalled. cfg_capacity_limit sets
// the occupancy at which a new key evicts; zero acts as one and values above ENTRIES saturate.
// Write it only while the block is idle. No clearing pass is needed after reset.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [WORD_BITS-1:0] in_req_key,
  input  logic [WORD_BITS-1:0] in_entry_word,
  input  logic [WORD_BITS-1:0] in_value_word,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_found,
  output logic [WORD_BITS-1:0] out_entry_out,
  output logic [WORD_BITS-1:0] out_value_out,
  // configuration channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CAP_BITS-1:0]  cfg_capacity_limit
);

  lkv_cmd_t cmd;
  lkv_sts_t sts;
  logic     cfg_we;

  // Configuration beat
  assign cfg_ready = rst_n;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Controller
  lkv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath
  lkv_dpath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_cap       (cfg_capacity_limit),
    .in_req_type   (in_req_type),
    .in_req_key    (in_req_key),
    .in_entry_word (in_entry_word),
    .in_value_word (in_value_word),
    .out_found     (out_found),
    .out_entry_out (out_entry_out),
    .out_value_out (out_value_out)
  );

`ifndef SYNTHESIS
  // An accepted beat keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a request is in flight");

  // A result never appears in the cycle right after a beat is accepted
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result produced before lookup finished");

  // Payload words are only returned with a hit
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> ((out_entry_out == '0) && (out_value_out == '0)))
    else $error("nonzero payload on a result without a hit");
`endif

endmodule

// ----- rtl/lkv_dpath.sv -----
// Datapath of the LRU cache: key store, recency ranks, payload memory and result register.
module lkv_dpath import lkv_pkg::*; #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lkv_cmd_t             cmd,
  output lkv_sts_t             sts,
  input  logic                 cfg_we,
  input  logic [CAP_BITS-1:0]  cfg_cap,
  input  logic [1:0]           in_req_type,
  input  logic [WORD_BITS-1:0] in_req_key,
  input  logic [WORD_BITS-1:0] in_entry_word,
  input  logic [WORD_BITS-1:0] in_value_word,
  output logic                 out_found,
  output logic [WORD_BITS-1:0] out_entry_out,
  output logic [WORD_BITS-1:0] out_value_out
);

  localparam int unsigned IDX_W  = $clog2(ENTRIES);
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;
  localparam logic [CMP_W-1:0] ENTRIES_C = CMP_W'(ENTRIES);

  // Request registers
  logic [1:0]           type_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [WORD_BITS-1:0] ent_r;
  logic [WORD_BITS-1:0] val_r;

  // Capacity register
  logic [CAP_BITS-1:0]  cap_r;

  // Slot state
  logic [ENTRIES-1:0]   valid_r;
  logic [KEY_BITS-1:0]  key_st_r  [ENTRIES];
  logic [IDX_W-1:0]     rank_r    [ENTRIES];
  logic [CNT_W-1:0]     occ_r;

  // Lookup results
  logic                 hit_r;
  logic                 full_r;
  logic [IDX_W-1:0]     tgt_idx_r;
  logic [IDX_W-1:0]     tgt_rank_r;

  // Payload memory, entry word in the upper half
  logic [2*WORD_BITS-1:0] mem [ENTRIES];
  logic [2*WORD_BITS-1:0] rd_r;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;

  // Result register
  logic                 found_r;
  logic [WORD_BITS-1:0] entry_o_r;
  logic [WORD_BITS-1:0] value_o_r;

  // Combinational lookup
  logic                 hit_c;
  logic [IDX_W-1:0]     hit_idx_c;
  logic [IDX_W-1:0]     hit_rank_c;
  logic [IDX_W-1:0]     lru_idx_c;
  logic [CNT_W-1:0]     occ_m1;
  logic [IDX_W-1:0]     lru_rank;
  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     occ_ext;
  logic                 full_c;

  // Lowest free slot
  logic [ENTRIES-1:0]   free_v;
  logic [ENTRIES-1:0]   free_oh;
  logic [IDX_W-1:0]     free_idx;
  logic                 free_any;

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      type_r <= in_req_type;
      key_r  <= in_req_key[KEY_BITS-1:0];
      ent_r  <= in_entry_word;
      val_r  <= in_value_word;
    end
  end

  // Capacity limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_cap;
    end
  end

  // Least recent slot holds rank occupancy-1
  assign occ_m1   = occ_r - CNT_W'(1);
  assign lru_rank = occ_m1[IDX_W-1:0];

  // Parallel key compare; keys are unique among valid slots so OR-encoding is exact
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    hit_rank_c = '0;
    lru_idx_c  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_r[i] && (key_st_r[i] == key_r)) begin
        hit_c      = 1'b1;
        hit_idx_c  = hit_idx_c | IDX_W'(i);
        hit_rank_c = hit_rank_c | rank_r[i];
      end
      if (valid_r[i] && (rank_r[i] == lru_rank)) begin
        lru_idx_c = lru_idx_c | IDX_W'(i);
      end
    end
  end

  // Full check: limit zero acts as one, limit above the slot count saturates
  assign cap_ext = CMP_W'(cap_r);
  assign occ_ext = CMP_W'(occ_r);
  assign full_c  = (cap_r == '0) ? (occ_r != '0)
                                 : ((occ_ext >= cap_ext) || (occ_ext >= ENTRIES_C));

  // Lowest free slot via isolate-lowest-set-bit
  assign free_v   = ~valid_r;
  assign free_oh  = free_v & (~free_v + ENTRIES'(1));
  assign free_any = |free_v;

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (free_oh[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

  // Register lookup; a miss targets the least recent slot for eviction
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r      <= hit_c;
      full_r     <= full_c;
      tgt_idx_r  <= hit_c ? hit_idx_c : lru_idx_c;
      tgt_rank_r <= hit_c ? hit_rank_c : lru_rank;
    end
  end

  // Valid bits, recency ranks and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rank_r  <= '{default: '0};
      occ_r   <= '0;
    end else begin
      if (cmd.touch) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (rank_r[i] < tgt_rank_r)) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
        rank_r[tgt_idx_r] <= '0;
      end
      if (cmd.drop) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && (rank_r[i] > tgt_rank_r)) begin
            rank_r[i] <= rank_r[i] - IDX_W'(1);
          end
        end
        valid_r[tgt_idx_r] <= 1'b0;
        rank_r[tgt_idx_r]  <= '0;
        occ_r              <= occ_r - CNT_W'(1);
      end
      if (cmd.insert && free_any) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i]) begin
            rank_r[i] <= rank_r[i] + IDX_W'(1);
          end
        end
        valid_r[free_idx] <= 1'b1;
        rank_r[free_idx]  <= '0;
        occ_r             <= occ_r + CNT_W'(1);
      end
    end
  end

  // Key store
  always_ff @(posedge clk) begin
    if (cmd.insert && free_any) begin
      key_st_r[free_idx] <= key_r;
    end
  end

  // Payload memory: one write port, one registered read at the target slot
  assign mem_we = cmd.mem_wr || (cmd.insert && free_any);
  assign mem_wa = cmd.insert ? free_idx : tgt_idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= {ent_r, val_r};
    end
    rd_r <= mem[tgt_idx_r];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found_r <= hit_r && (type_r != REQ_NOP);
      if ((type_r == REQ_GET) && hit_r) begin
        entry_o_r <= rd_r[2*WORD_BITS-1:WORD_BITS];
        value_o_r <= rd_r[WORD_BITS-1:0];
      end else begin
        entry_o_r <= '0;
        value_o_r <= '0;
      end
    end
  end

  assign sts.req_type  = type_r;
  assign sts.hit       = hit_r;
  assign sts.full      = full_r;

  assign out_found     = found_r;
  assign out_entry_out = entry_o_r;
  assign out_value_out = value_o_r;

endmodule

// ----- rtl/lkv_ctrl.sv -----
// Controller of the LRU cache: request sequencing and input/output handshakes.
module lkv_ctrl import lkv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output lkv_cmd_t cmd,
  input  lkv_sts_t sts
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_EXEC = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  // Next state and commands
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        unique case (sts.req_type)
          REQ_GET: begin
            cmd.touch = sts.hit;
          end
          REQ_PUT: begin
            if (sts.hit) begin
              cmd.touch  = 1'b1;
              cmd.mem_wr = 1'b1;
            end else begin
              // new key: evict the least recent first when at capacity
              cmd.drop  = sts.full;
              state_nxt = ST_INS;
            end
          end
          REQ_DEL: begin
            cmd.drop = sts.hit;
          end
          default: begin
          end
        endcase
      end
      ST_INS: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // wait for the result register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the LRU key-value cache: directed requests, then random traffic.
`timescale 1ns / 1ps

module tb_top import lkv_pkg::*;;

  localparam int LINES      = 16;
  localparam int CYCLE_CAP  = 400000;
  localparam int SHOW_LIMIT = 10;

  typedef struct packed {
    logic                 found;
    logic [WORD_BITS-1:0] entry;
    logic [WORD_BITS-1:0] value;
  } cache_result_t;

  // DUT connections; every input starts at a known value
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_req_type = REQ_NOP;
  logic [WORD_BITS-1:0] in_req_key = '0;
  logic [WORD_BITS-1:0] in_entry_word = '0;
  logic [WORD_BITS-1:0] in_value_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_found;
  logic [WORD_BITS-1:0] out_entry_out;
  logic [WORD_BITS-1:0] out_value_out;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CAP_BITS-1:0]  cfg_capacity_limit = CAP_RESET;

  lru_key_value_cache dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_req_key         (in_req_key),
    .in_entry_word      (in_entry_word),
    .in_value_word      (in_value_word),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_found          (out_found),
    .out_entry_out      (out_entry_out),
    .out_value_out      (out_value_out),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_capacity_limit (cfg_capacity_limit)
  );

  // Shadow copy of the cache contents
  logic                 line_valid [LINES];
  logic [WORD_BITS-1:0] line_key   [LINES];
  logic [WORD_BITS-1:0] line_entry [LINES];
  logic [WORD_BITS-1:0] line_value [LINES];
  logic [3:0]           line_rank  [LINES];
  logic [CAP_BITS-1:0]  line_count;
  logic [CAP_BITS-1:0]  cap_setting;

  cache_result_t        pending_results[$];
  logic [WORD_BITS-1:0] key_pool[$];
  int                   fail_count = 0;
  bit                   quiet_mode = 1'b0;
  int                   stall_left = 0;

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("lru_key_value_cache regression: fail");
    $finish;
  end

  // Move line s to most recent; more recent lines age by one
  function automatic void promote_line(int s);
    logic [3:0] r;
    r = line_rank[s];
    for (int i = 0; i < LINES; i++)
      if (line_valid[i] && line_rank[i] < r) line_rank[i]++;
    line_rank[s] = '0;
  endfunction

  // Invalidate line s; less recent lines move up by one
  function automatic void evict_line(int s);
    logic [3:0] r;
    r = line_rank[s];
    line_valid[s] = 1'b0;
    line_rank[s]  = '0;
    for (int i = 0; i < LINES; i++)
      if (line_valid[i] && line_rank[i] > r) line_rank[i]--;
    if (line_count > 0) line_count--;
  endfunction

  // Expected result of one request; updates the shadow copy
  function automatic cache_result_t cache_lookup(input logic [1:0] op,
                                                 input logic [WORD_BITS-1:0] key,
                                                 input logic [WORD_BITS-1:0] ent,
                                                 input logic [WORD_BITS-1:0] val);
    cache_result_t res;
    logic [CAP_BITS-1:0] eff_cap;
    int hit_idx;
    int victim;
    int free_idx;
    res = '0;
    eff_cap = cap_setting;
    if (eff_cap == 0) eff_cap = 1;
    if (eff_cap > LINES) eff_cap = LINES;
    hit_idx = -1;
    for (int i = LINES - 1; i >= 0; i--)
      if (line_valid[i] && line_key[i] == key) hit_idx = i;
    case (op)
      REQ_GET: begin
        if (hit_idx >= 0) begin
          res.found = 1'b1;
          res.entry = line_entry[hit_idx];
          res.value = line_value[hit_idx];
          promote_line(hit_idx);
        end
      end
      REQ_PUT: begin
        if (hit_idx >= 0) begin
          res.found = 1'b1;
          line_entry[hit_idx] = ent;
          line_value[hit_idx] = val;
          promote_line(hit_idx);
        end else begin
          if (line_count >= eff_cap) begin
            victim = -1;
            for (int i = 0; i < LINES; i++)
              if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) victim = i;
            if (victim >= 0) evict_line(victim);
          end
          free_idx = -1;
          for (int i = LINES - 1; i >= 0; i--)
            if (!line_valid[i]) free_idx = i;
          if (free_idx >= 0) begin
            for (int i = 0; i < LINES; i++)
              if (line_valid[i]) line_rank[i]++;
            line_valid[free_idx] = 1'b1;
            line_key[free_idx]   = key;
            line_entry[free_idx] = ent;
            line_value[free_idx] = val;
            line_rank[free_idx]  = '0;
            line_count++;
          end
        end
      end
      REQ_DEL: begin
        if (hit_idx >= 0) begin
          res.found = 1'b1;
          evict_line(hit_idx);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Idle length: mostly short, a few long
  function automatic int rand_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (quiet_mode) begin
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(0, 4);
        end
        6, 7, 8: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 3);
        end
        default: begin
          out_stall  <= ($urandom_range(0, 2) != 0);
          stall_left <= $urandom_range(10, 40);
        end
      endcase
    end
  end

  // Result checker: each accepted beat against the oldest expectation
  always @(posedge clk) begin
    cache_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("unexpected result beat: found=%0b entry=%h value=%h",
                   out_found, out_entry_out, out_value_out);
      end else begin
        want = pending_results.pop_front();
        if (out_found !== want.found || out_entry_out !== want.entry ||
            out_value_out !== want.value) begin
          fail_count++;
          if (fail_count <= SHOW_LIMIT)
            $display("mismatch: found exp %0b got %0b, entry exp %h got %h, value exp %h got %h",
                     want.found, out_found, want.entry, out_entry_out,
                     want.value, out_value_out);
        end
      end
    end
  end

  // Send one request beat after a random idle gap
  task automatic send_req(input logic [1:0] op, input logic [WORD_BITS-1:0] key,
                          input logic [WORD_BITS-1:0] ent, input logic [WORD_BITS-1:0] val);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= op;
    in_req_key    <= key;
    in_entry_word <= ent;
    in_value_word <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(cache_lookup(op, key, ent, val));
  endtask

  // Hold the sender until every expected result has come
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Capacity write while idle
  task automatic write_capacity(input logic [CAP_BITS-1:0] lim);
    wait_drain();
    repeat (8) @(posedge clk);
    cfg_valid          <= 1'b1;
    cfg_capacity_limit <= lim;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    cap_setting = lim;
  endtask

  task automatic build_pool(input int n);
    key_pool.delete();
    key_pool.push_back('0);
    key_pool.push_back('1);
    for (int i = 2; i < n; i++) key_pool.push_back(rand_word());
  endtask

  // Directed: extremes, every request code, hit/miss on each
  task automatic test_basic_requests();
    send_req(REQ_GET, '0, '0, '0);           // miss on empty cache
    send_req(REQ_PUT, '0, '0, '0);
    send_req(REQ_GET, '0, '1, '1);           // hit, payload ignored
    send_req(REQ_PUT, '1, '1, '1);
    send_req(REQ_GET, '1, '0, '0);
    send_req(REQ_PUT, '0, 64'hA5A5_5A5A_0F0F_F0F0, 64'h1234_5678_9ABC_DEF0);
    send_req(REQ_GET, '0, '0, '0);           // overwrite visible
    send_req(REQ_DEL, '0, '1, '1);
    send_req(REQ_DEL, '0, '0, '0);           // remove of absent key
    send_req(REQ_GET, '0, '0, '0);
    send_req(REQ_NOP, '1, '1, '1);           // unused code, no effect
    send_req(REQ_GET, '1, '0, '0);
    send_req(REQ_NOP, '0, '0, '0);
  endtask

  // Directed: capacity zero acts as one
  task automatic test_capacity_floor();
    write_capacity('0);
    send_req(REQ_PUT, 64'h11, rand_word(), rand_word());   // evicts the resident key
    send_req(REQ_PUT, 64'h22, rand_word(), rand_word());   // evicts 0x11
    send_req(REQ_GET, 64'h11, '0, '0);
    send_req(REQ_GET, 64'h22, '0, '0);
    send_req(REQ_GET, '1, '0, '0);
  endtask

  // Random traffic on a key pool sized against the capacity
  task automatic run_traffic(input int pool_n, input int count);
    int r;
    logic [WORD_BITS-1:0] key;
    build_pool(pool_n);
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(0, 99);
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (r < 40)      send_req(REQ_GET, key, rand_word(), rand_word());
      else if (r < 80) send_req(REQ_PUT, key, rand_word(), rand_word());
      else if (r < 92) send_req(REQ_DEL, key, rand_word(), rand_word());
      else if (r < 96) send_req(REQ_NOP, key, rand_word(), rand_word());
      else             send_req(r[0] ? REQ_PUT : REQ_GET, rand_word(), rand_word(), rand_word());
    end
  endtask

  // Several capacity settings; some steps leave the cache fuller than the next limit
  task automatic test_capacity_sweep();
    write_capacity(5'd16);
    run_traffic(24, 150);
    write_capacity(5'd3);          // below occupancy
    run_traffic(6, 120);
    write_capacity(5'd31);         // saturates to the line count
    run_traffic(24, 150);
    write_capacity(5'd0);
    run_traffic(3, 100);
    write_capacity(5'd1);
    run_traffic(3, 80);
    write_capacity(5'd2);
    run_traffic(4, 100);
    quiet_mode = 1'b1;             // back-to-back stretch
    write_capacity(5'd8);
    run_traffic(12, 120);
    quiet_mode = 1'b0;
    write_capacity(5'd17);
    run_traffic(22, 130);
    write_capacity(5'd5);
    run_traffic(7, 100);
    write_capacity(5'd12);
    run_traffic(14, 100);
  endtask

  // Sender holds until the result side has fully drained, then resumes
  task automatic test_drain_pause();
    run_traffic(10, 30);
    wait_drain();
    run_traffic(10, 30);
  endtask

  initial begin
    for (int i = 0; i < LINES; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_entry[i] = '0;
      line_value[i] = '0;
      line_rank[i]  = '0;
    end
    line_count  = '0;
    cap_setting = CAP_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_requests();
    test_capacity_floor();
    test_capacity_sweep();
    test_drain_pause();

    wait_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("lru_key_value_cache regression: pass");
    end else begin
      $display("lru_key_value_cache regression: fail");
    end
    $finish;
  end

endmodule
